@@ design/tpid_pkg.sv @@
// Shared constants, types and helper functions for the temperature PID controller.
`default_nettype none

package tpid_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned DTermW   = 17;
  localparam int unsigned SumW     = 18;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [DataW-1:0] SegKnee  = 8'd189;
  localparam logic [DataW-1:0] LoSlope  = 8'd105;
  localparam logic [DataW-1:0] LoOffset = 8'd17;
  localparam logic [DataW-1:0] HiSlope  = 8'd225;
  localparam logic [DataW-1:0] HiOffset = 8'd106;
  localparam logic [DataW-1:0] ClampTop = 8'd255;

  localparam logic [DataW-1:0] SetpointReset = 8'd30;
  localparam logic [DataW-1:0] GainPReset    = 8'd128;
  localparam logic [DataW-1:0] GainIReset    = 8'd1;
  localparam logic [DataW-1:0] GainDReset    = 8'd40;

  typedef enum logic [CfgIdxW-1:0] {
    RegSetpoint = 2'd0,
    RegGainP    = 2'd1,
    RegGainI    = 2'd2,
    RegGainD    = 2'd3
  } cfg_reg_t;

  typedef logic [DataW-1:0]         byte_t;
  typedef logic signed [DTermW-1:0] dterm_t;
  typedef logic signed [SumW-1:0]   sum_t;

  function automatic byte_t to_temperature(input byte_t s);
    logic [2*DataW-1:0] prod;
    begin
      if (s < SegKnee) begin
        prod = LoSlope * s;
        to_temperature = prod[2*DataW-1:DataW] - LoOffset;
      end else begin
        prod = HiSlope * s;
        to_temperature = prod[2*DataW-1:DataW] - HiOffset;
      end
    end
  endfunction

  function automatic byte_t clamp_byte(input sum_t v);
    begin
      if (v < 0) begin
        clamp_byte = '0;
      end else if (v > $signed({{(SumW-DataW){1'b0}}, ClampTop})) begin
        clamp_byte = ClampTop;
      end else begin
        clamp_byte = v[DataW-1:0];
      end
    end
  endfunction

endpackage

`default_nettype wire

@@ design/tpid_if.sv @@
// Valid/ready channel interfaces for samples in and controller results out.
`default_nettype none

interface tpid_in_if;
  logic               valid;
  logic               ready;
  tpid_pkg::byte_t    adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface tpid_out_if;
  logic               valid;
  logic               ready;
  tpid_pkg::byte_t    duty;
  tpid_pkg::byte_t    temperature;
  tpid_pkg::byte_t    p_term;
  tpid_pkg::byte_t    i_term;
  tpid_pkg::dterm_t   d_term;

  modport source (output valid, output duty, output temperature, output p_term,
                  output i_term, output d_term, input ready);
  modport sink   (input valid, input duty, input temperature, input p_term,
                  input i_term, input d_term, output ready);
endinterface

`default_nettype wire

@@ design/temperature_pid_pwm_controller_core.sv @@
// Temperature PID controller core: sample to temperature, PID terms, clamped PWM duty.
//
// Usage:
//   sample_ch carries one 8-bit converter sample per transfer; result_ch carries
//   duty, temperature, p_term, i_term and the signed 17-bit d_term, one result
//   per sample, in order.
//   Registers setpoint, gain_p, gain_i and gain_d are written through cfg_we,
//   cfg_index and cfg_data; the user must write them only while no sample is
//   in flight, which the block itself does not enforce.
//   The sample stage registers temperature and error; the result stage forms
//   the PID terms and the duty into the result register, where integral and
//   previous error update as well.
//   Throughput: one sample per cycle while result_ch does not stall.
//   Reset (rst, synchronous, active high) restores the register defaults,
//   clears integral and previous error and empties both stages.
//   When result_ch stalls, the result holds, the sample stage fills once more
//   and then sample_ch.ready drops until the result is taken.
`default_nettype none

module temperature_pid_pwm_controller_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [tpid_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [tpid_pkg::DataW-1:0]     cfg_data,
  tpid_in_if.sink                             sample_ch,
  tpid_out_if.source                          result_ch
);

  tpid_pkg::byte_t setpoint;
  tpid_pkg::byte_t gain_p;
  tpid_pkg::byte_t gain_i;
  tpid_pkg::byte_t gain_d;

  tpid_pkg::byte_t integral;
  logic signed [tpid_pkg::DataW-1:0] prev_error;

  logic                              stage_valid;
  tpid_pkg::byte_t                   stage_temp;
  logic signed [tpid_pkg::DataW-1:0] stage_err;

  logic                              out_valid;
  logic                              advance;
  tpid_pkg::byte_t                   temp_next;

  logic signed [tpid_pkg::DTermW-1:0] p_raw;
  tpid_pkg::sum_t                     i_raw;
  logic signed [tpid_pkg::DataW:0]    err_diff;
  tpid_pkg::dterm_t                   d_raw;
  tpid_pkg::byte_t                    p_clamped;
  tpid_pkg::byte_t                    i_clamped;
  tpid_pkg::dterm_t                   d_sel;
  tpid_pkg::sum_t                     total;

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= tpid_pkg::SetpointReset;
      gain_p   <= tpid_pkg::GainPReset;
      gain_i   <= tpid_pkg::GainIReset;
      gain_d   <= tpid_pkg::GainDReset;
    end else if (cfg_we) begin
      unique case (tpid_pkg::cfg_reg_t'(cfg_index))
        tpid_pkg::RegSetpoint: setpoint <= cfg_data;
        tpid_pkg::RegGainP:    gain_p   <= cfg_data;
        tpid_pkg::RegGainI:    gain_i   <= cfg_data;
        tpid_pkg::RegGainD:    gain_d   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance         = !out_valid || result_ch.ready;
  assign sample_ch.ready = !stage_valid || advance;
  assign temp_next       = tpid_pkg::to_temperature(sample_ch.adc_sample);

  // sample stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sample_ch.ready) begin
      stage_valid <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ch.valid && sample_ch.ready) begin
      stage_temp <= temp_next;
      stage_err  <= $signed(temp_next - setpoint);
    end
  end

  always_comb begin
    p_raw     = $signed({1'b0, gain_p}) * stage_err;
    i_raw     = $signed({{(tpid_pkg::SumW-tpid_pkg::DataW){1'b0}}, integral})
              + $signed({1'b0, gain_i}) * stage_err;
    err_diff  = {prev_error[tpid_pkg::DataW-1], prev_error}
              - {stage_err[tpid_pkg::DataW-1], stage_err};
    d_raw     = $signed({1'b0, gain_d}) * err_diff;
    p_clamped = tpid_pkg::clamp_byte({p_raw[tpid_pkg::DTermW-1], p_raw});
    i_clamped = tpid_pkg::clamp_byte(i_raw);
    d_sel     = (p_clamped == '0 && i_clamped == '0) ? '0 : d_raw;
    total     = $signed({{(tpid_pkg::SumW-tpid_pkg::DataW){1'b0}}, p_clamped})
              + $signed({{(tpid_pkg::SumW-tpid_pkg::DataW){1'b0}}, i_clamped})
              + $signed({d_sel[tpid_pkg::DTermW-1], d_sel});
  end

  // result stage and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      integral   <= '0;
      prev_error <= '0;
    end else if (advance) begin
      out_valid <= stage_valid;
      if (stage_valid) begin
        integral   <= i_clamped;
        prev_error <= stage_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      result_ch.duty        <= tpid_pkg::clamp_byte(total);
      result_ch.temperature <= stage_temp;
      result_ch.p_term      <= p_clamped;
      result_ch.i_term      <= i_clamped;
      result_ch.d_term      <= d_sel;
    end
  end

  assign result_ch.valid = out_valid;

endmodule

`default_nettype wire

@@ design/tpid_checker.sv @@
// Port-level checks for the temperature PID controller core, bound to the core module.
`default_nettype none

module tpid_checker (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire tpid_pkg::byte_t         duty,
  input wire tpid_pkg::byte_t         p_term,
  input wire tpid_pkg::byte_t         i_term,
  input wire tpid_pkg::dterm_t        d_term
);

  logic [tpid_pkg::DataW:0] pi_sum;
  assign pi_sum = {1'b0, p_term} + {1'b0, i_term};

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_ready_only_blocked_by_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("sample channel blocked without a stalled result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(duty) && $stable(d_term))
    else $error("stalled result changed");

  a_idle_loop_no_d: assert property (@(posedge clk) disable iff (rst)
    out_valid && p_term == '0 && i_term == '0 |-> d_term == '0)
    else $error("derivative nonzero with p and i zero");

  a_duty_without_d: assert property (@(posedge clk) disable iff (rst)
    out_valid && d_term == '0 |->
      duty == ((pi_sum > {1'b0, tpid_pkg::ClampTop}) ? tpid_pkg::ClampTop
                                                     : pi_sum[tpid_pkg::DataW-1:0]))
    else $error("duty does not match p plus i");

endmodule

bind temperature_pid_pwm_controller_core tpid_checker u_tpid_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample_ch.ready),
  .out_valid (result_ch.valid),
  .out_ready (result_ch.ready),
  .duty      (result_ch.duty),
  .p_term    (result_ch.p_term),
  .i_term    (result_ch.i_term),
  .d_term    (result_ch.d_term)
);

`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the temperature PID controller core: predicts each result and checks it.
`default_nettype none

module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseItems = 75;
  localparam int unsigned RandPhases = 6;

  typedef struct packed {
    tpid_pkg::byte_t  duty;
    tpid_pkg::byte_t  temperature;
    tpid_pkg::byte_t  p_term;
    tpid_pkg::byte_t  i_term;
    tpid_pkg::dterm_t d_term;
  } pid_result_t;

  logic  clk = 1'b0;
  logic  rst;
  logic  cfg_we;
  logic  [tpid_pkg::CfgIdxW-1:0] cfg_index;
  tpid_pkg::byte_t cfg_data;

  tpid_in_if  sample_ch ();
  tpid_out_if result_ch ();

  temperature_pid_pwm_controller_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  tpid_pkg::byte_t setpoint = tpid_pkg::SetpointReset;
  tpid_pkg::byte_t gain_p   = tpid_pkg::GainPReset;
  tpid_pkg::byte_t gain_i   = tpid_pkg::GainIReset;
  tpid_pkg::byte_t gain_d   = tpid_pkg::GainDReset;
  tpid_pkg::byte_t heat_integral = '0;
  tpid_pkg::byte_t last_error    = '0;

  tpid_pkg::byte_t sample_queue[$];
  pid_result_t     duty_expected[$];
  int unsigned samples_queued = 0;
  int unsigned samples_taken  = 0;
  int unsigned results_seen   = 0;
  int unsigned bad_results    = 0;
  int unsigned cycles         = 0;

  int unsigned src_gap, src_calm, snk_gap, snk_calm, hold_left;
  logic        hold_done;

  tpid_pkg::byte_t s_list_a[] = '{8'd0, 8'd255, 8'd188, 8'd189, 8'd41, 8'd42, 8'd100,
                                  8'd200, 8'd130};

  always #5 clk = ~clk;

  function automatic int clamp_to_byte(input int v);
    if (v < 0) return 0;
    if (v > 255) return 255;
    return v;
  endfunction

  // advance the controller state by one sample
  function automatic pid_result_t control_step(input tpid_pkg::byte_t s);
    logic [15:0]     prod;
    tpid_pkg::byte_t t, err_bits;
    int              e, pe, p, i, d;
    pid_result_t     r;
    if (s < tpid_pkg::SegKnee) begin
      prod = 16'(tpid_pkg::LoSlope) * 16'(s);
      t = prod[15:8] - tpid_pkg::LoOffset;
    end else begin
      prod = 16'(tpid_pkg::HiSlope) * 16'(s);
      t = prod[15:8] - tpid_pkg::HiOffset;
    end
    err_bits = t - setpoint;
    e  = int'($signed(err_bits));
    pe = int'($signed(last_error));
    p  = clamp_to_byte(int'(gain_p) * e);
    i  = clamp_to_byte(int'(heat_integral) + int'(gain_i) * e);
    d  = int'(gain_d) * (pe - e);
    if (p + i == 0) d = 0;
    heat_integral = tpid_pkg::byte_t'(i);
    last_error    = err_bits;
    r.duty        = tpid_pkg::byte_t'(clamp_to_byte(p + i + d));
    r.temperature = t;
    r.p_term      = tpid_pkg::byte_t'(p);
    r.i_term      = tpid_pkg::byte_t'(i);
    r.d_term      = tpid_pkg::dterm_t'(d);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  task automatic report(input bit has_want, input pid_result_t want, input pid_result_t got);
    bad_results++;
    if (bad_results <= 10) begin
      if (!has_want)
        $display("unexpected result: duty %0d temp %0d p %0d i %0d d %0d",
                 got.duty, got.temperature, got.p_term, got.i_term, got.d_term);
      else
        $display("mismatch exp duty %0d temp %0d p %0d i %0d d %0d / got %0d %0d %0d %0d %0d",
                 want.duty, want.temperature, want.p_term, want.i_term, want.d_term,
                 got.duty, got.temperature, got.p_term, got.i_term, got.d_term);
    end
  endtask

  task automatic write_reg(input tpid_pkg::cfg_reg_t idx, input tpid_pkg::byte_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    unique case (idx)
      tpid_pkg::RegSetpoint: setpoint = val;
      tpid_pkg::RegGainP:    gain_p   = val;
      tpid_pkg::RegGainI:    gain_i   = val;
      tpid_pkg::RegGainD:    gain_d   = val;
    endcase
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_loop(input tpid_pkg::byte_t sp, input tpid_pkg::byte_t gp,
                          input tpid_pkg::byte_t gi, input tpid_pkg::byte_t gd);
    write_reg(tpid_pkg::RegSetpoint, sp);
    write_reg(tpid_pkg::RegGainP, gp);
    write_reg(tpid_pkg::RegGainI, gi);
    write_reg(tpid_pkg::RegGainD, gd);
  endtask

  task automatic push_sample(input tpid_pkg::byte_t s);
    sample_queue.push_back(s);
    samples_queued++;
  endtask

  task automatic drain();
    while (results_seen < samples_queued) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL temperature_pid_pwm_controller_core");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      src_gap  <= 0;
      src_calm <= 0;
    end else if (!sample_ch.valid || sample_ch.ready) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        sample_ch.valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        sample_ch.valid      <= 1'b1;
        sample_ch.adc_sample <= sample_queue.pop_front();
        if (src_calm > 0) src_calm <= src_calm - 1;
        else if ($urandom_range(0, 99) < 4) src_calm <= $urandom_range(20, 60);
        else if ($urandom_range(0, 2) == 0) src_gap <= pick_gap();
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // hold off the result side once for a long stretch to back up the input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && samples_taken >= 120) begin
      hold_left <= 80;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      snk_gap  <= 0;
      snk_calm <= 0;
    end else if (snk_gap > 0) begin
      snk_gap <= snk_gap - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= (hold_left == 0);
      if (snk_calm > 0) snk_calm <= snk_calm - 1;
      else if ($urandom_range(0, 99) < 4) snk_calm <= $urandom_range(20, 60);
      else if ($urandom_range(0, 3) == 0) snk_gap <= pick_gap();
    end
  end

  always @(posedge clk) begin
    pid_result_t got, want;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got = '{result_ch.duty, result_ch.temperature, result_ch.p_term,
                result_ch.i_term, result_ch.d_term};
        results_seen++;
        if (duty_expected.size() == 0) begin
          report(1'b0, '0, got);
        end else begin
          want = duty_expected.pop_front();
          if (got.duty !== want.duty || got.temperature !== want.temperature ||
              got.p_term !== want.p_term || got.i_term !== want.i_term ||
              got.d_term !== want.d_term)
            report(1'b1, want, got);
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        duty_expected.push_back(control_step(sample_ch.adc_sample));
        samples_taken++;
      end
    end
  end

  initial begin
    tpid_pkg::byte_t s;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = tpid_pkg::RegSetpoint;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_loop(tpid_pkg::SetpointReset, tpid_pkg::GainPReset, tpid_pkg::GainIReset,
             tpid_pkg::GainDReset);
    foreach (s_list_a[k]) push_sample(s_list_a[k]);
    drain();

    // large error drives a negative sum, then a cold reading idles the loop
    set_loop(8'd0, 8'd255, 8'd255, 8'd255);
    push_sample(8'd255);
    push_sample(8'd0);
    drain();

    // error swings between +127 and -128 for the widest derivative both ways
    set_loop(8'd189, 8'd255, 8'd1, 8'd255);
    push_sample(8'd188);
    push_sample(8'd188);
    push_sample(8'd191);
    push_sample(8'd188);
    drain();

    for (int ph = 0; ph < RandPhases; ph++) begin
      case (ph)
        0:       set_loop(8'd0, 8'd0, 8'd0, 8'd0);
        1:       set_loop(8'd255, 8'd255, 8'd255, 8'd255);
        2:       set_loop(tpid_pkg::SetpointReset, tpid_pkg::GainPReset,
                          tpid_pkg::GainIReset, tpid_pkg::GainDReset);
        default: set_loop(8'($urandom_range(0, 255)), 8'($urandom_range(0, 16)),
                          8'($urandom_range(0, 4)), 8'($urandom_range(0, 255)));
      endcase
      s = 8'($urandom_range(0, 255));
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 9) < 4) s = 8'($urandom_range(0, 255));
        else s = s + tpid_pkg::byte_t'($urandom_range(0, 12)) - 8'd6;
        push_sample(s);
      end
      drain();
    end

    repeat (6) @(posedge clk);
    if (bad_results == 0 && duty_expected.size() == 0)
      $display("PASS temperature_pid_pwm_controller_core");
    else
      $display("FAIL temperature_pid_pwm_controller_core");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/tpid_pkg.sv
design/tpid_if.sv
design/temperature_pid_pwm_controller_core.sv
design/tpid_checker.sv
tb/tb.sv
